// ===== rtl/core/rti_pkg.sv =====
package rti_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int FRAC_BITS   = 12;
  localparam int NORM_BITS   = 11;
  localparam int BARY_BITS   = 12;
  localparam int DIST_BITS   = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = ((DIST_BITS + 2 * (BARY_BITS + 1) + 7) / 8) * 8;
  localparam int OUT_USER_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO = 2'd3;

  localparam logic [2:0] CAUSE_HIT      = 3'd0;
  localparam logic [2:0] CAUSE_PARALLEL = 3'd1;
  localparam logic [2:0] CAUSE_U_OUT    = 3'd2;
  localparam logic [2:0] CAUSE_V_OUT    = 3'd3;
  localparam logic [2:0] CAUSE_BEHIND   = 3'd4;

endpackage

// ===== rtl/core/ray_triangle_intersect.sv =====
// Double-sided ray/triangle intersection test. The triangle's three vertices and the
// near-zero threshold are written through the cfg port; the user must write them only
// while no ray is in flight, which the block itself does not enforce. Each ray on in_tdata
// (origin in the low bits, direction above it, x,y,z per vector from the high end down,
// signed fixed point) gives exactly one result on out_tdata/out_tuser: hit flag, miss cause,
// distance along the normalized direction (saturating) and barycentric u, v; on a miss the
// numeric fields are zero. The block is a fully pipelined datapath: while the output is not
// stalled, one ray can enter every cycle, and results leave in order. The pipe holds the
// bit-per-stage square root of the direction length, the bit-per-stage normalizing divide and
// the 32-stage divide that produces distance and barycentrics. A stalled output freezes the whole pipe.
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS,
  localparam int IN_W       = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [3*COORD_WIDTH-1:0]        cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // origin_xyz, direction_xyz
  input  logic [IN_W-1:0]                 in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // distance, bary_u, bary_v
  output logic [rti_pkg::OUT_DATA_W-1:0]  out_tdata,
  // hit, miss_cause
  output logic [rti_pkg::OUT_USER_W-1:0]  out_tuser
);

  localparam int CW    = COORD_WIDTH;
  localparam int NB    = rti_pkg::NORM_BITS;
  localparam int BB    = rti_pkg::BARY_BITS;
  localparam int DQ    = rti_pkg::DIST_BITS;
  localparam int TW    = CW + 1;
  localparam int SN_W  = 2 * CW + 2 * NB;
  localparam int RW    = CW + NB;
  localparam int SQR_W = RW + 2;
  localparam int QN    = FRAC_BITS + 1;
  localparam int DW    = QN + 1;
  localparam int PW    = DW + TW + 1;
  localparam int QW    = 2 * TW + 1;
  localparam int SW    = (3 * TW + 3 > 2 * TW + DW + 3) ? 3 * TW + 3 : 2 * TW + DW + 3;
  localparam int TH_W  = SW + 2 * FRAC_BITS;
  localparam int NX_W  = SW + DQ;

  typedef struct packed {
    logic [2:0][TW-1:0] t;
    logic [2:0][CW-1:0] dm;
    logic [2:0]         dn;
  } ray_t;

  typedef struct packed {
    ray_t             ray;
    logic [SN_W-1:0]  n;
    logic [SQR_W-1:0] rem;
    logic [RW-1:0]    root;
  } sqst_t;

  typedef struct packed {
    ray_t              ray;
    logic [RW-1:0]     lq;
    logic [2:0][RW:0]  r;
    logic [2:0][QN-1:0] q;
  } nmst_t;

  typedef struct packed {
    logic [SW:0]    r;
    logic [DQ-1:0]  q;
    logic [DQ-1:0]  nlo;
  } dlane_t;

  typedef struct packed {
    logic [2:0]         cause;
    logic               sat;
    logic [SW-1:0]      den;
    dlane_t [2:0]       ln;
  } dvst_t;

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  // configuration
  logic [3*CW-1:0] va_r, vb_r, vc_r;
  logic [CW-1:0]   nz_r;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= {ONE, {CW{1'b0}}, {CW{1'b0}}};
      vb_r <= {{CW{1'b0}}, ONE, {CW{1'b0}}};
      vc_r <= {ONE, ONE, {CW{1'b0}}};
      nz_r <= CW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        rti_pkg::REG_VERTEX_A:  va_r <= cfg_data;
        rti_pkg::REG_VERTEX_B:  vb_r <= cfg_data;
        rti_pkg::REG_VERTEX_C:  vc_r <= cfg_data;
        rti_pkg::REG_NEAR_ZERO: nz_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] va_c [3];
  logic signed [TW-1:0] e1_c [3];
  logic signed [TW-1:0] e2_c [3];
  logic signed [CW-1:0] o_c  [3];
  logic signed [CW-1:0] dr_c [3];
  ray_t                 a_ray_nxt;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    logic signed [CW-1:0] vb_k, vc_k;
    assign va_c[k] = va_r[(2-k)*CW +: CW];
    assign vb_k    = vb_r[(2-k)*CW +: CW];
    assign vc_k    = vc_r[(2-k)*CW +: CW];
    assign e1_c[k] = {vb_k[CW-1], vb_k} - {va_c[k][CW-1], va_c[k]};
    assign e2_c[k] = {vc_k[CW-1], vc_k} - {va_c[k][CW-1], va_c[k]};
    assign o_c[k]  = in_tdata[(2-k)*CW +: CW];
    assign dr_c[k] = in_tdata[3*CW + (2-k)*CW +: CW];
    assign a_ray_nxt.t[k]  = {o_c[k][CW-1], o_c[k]} - {va_c[k][CW-1], va_c[k]};
    assign a_ray_nxt.dm[k] = dr_c[k][CW-1] ? CW'(-dr_c[k]) : CW'(dr_c[k]);
    assign a_ray_nxt.dn[k] = dr_c[k][CW-1];
  end

  // stage a: offsets, magnitudes, squares
  logic            a_v_r;
  ray_t            a_ray_r;
  logic [2*CW-1:0] a_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (ce) a_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_ray_r <= a_ray_nxt;
      for (int k = 0; k < 3; k++) begin
        a_sq_r[k] <= (2*CW)'(a_ray_nxt.dm[k]) * (2*CW)'(a_ray_nxt.dm[k]);
      end
    end
  end

  // stage b: squared length scaled for the root
  logic          b_v_r;
  sqst_t         b_r, b_nxt;
  logic [2*CW+1:0] msq;

  always_comb begin
    msq = (2*CW+2)'(a_sq_r[0]) + (2*CW+2)'(a_sq_r[1]) + (2*CW+2)'(a_sq_r[2]);
    b_nxt.ray  = a_ray_r;
    b_nxt.n    = {msq[2*CW-1:0], {(2*NB){1'b0}}};
    b_nxt.rem  = '0;
    b_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (ce) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (ce) b_r <= b_nxt;
  end

  // square root, one result bit per stage
  logic  sq_v_r [RW];
  sqst_t sq_r   [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sq
    localparam int I = RW - 1 - j;
    sqst_t            cur, sq_nxt;
    logic             cur_v;
    logic [SQR_W-1:0] rsh, trial;
    logic             ge;
    if (j == 0) begin : g_first
      assign cur   = b_r;
      assign cur_v = b_v_r;
    end else begin : g_next
      assign cur   = sq_r[j-1];
      assign cur_v = sq_v_r[j-1];
    end
    always_comb begin
      rsh    = {cur.rem[SQR_W-3:0], cur.n[2*I +: 2]};
      trial  = {cur.root, 2'b01};
      ge     = rsh >= trial;
      sq_nxt = cur;
      sq_nxt.rem  = ge ? rsh - trial : rsh;
      sq_nxt.root = {cur.root[RW-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j] <= 1'b0;
      else if (ce) sq_v_r[j] <= cur_v;
    end
    always_ff @(posedge clk) begin
      if (ce) sq_r[j] <= sq_nxt;
    end
  end

  // direction normalize, one quotient bit per stage for each component
  nmst_t n0;
  logic  nm_v_r [QN];
  nmst_t nm_r   [QN];

  always_comb begin
    n0.ray = sq_r[RW-1].ray;
    n0.lq  = sq_r[RW-1].root;
    for (int k = 0; k < 3; k++) begin
      n0.r[k] = (RW+1)'(sq_r[RW-1].ray.dm[k]) << (NB - 1);
      n0.q[k] = '0;
    end
  end

  for (genvar j = 0; j < QN; j++) begin : g_nm
    nmst_t cur, nm_nxt;
    logic  cur_v;
    if (j == 0) begin : g_first
      assign cur   = n0;
      assign cur_v = sq_v_r[RW-1];
    end else begin : g_next
      assign cur   = nm_r[j-1];
      assign cur_v = nm_v_r[j-1];
    end
    always_comb begin
      logic [RW:0] rsh;
      logic        ge;
      nm_nxt = cur;
      for (int k = 0; k < 3; k++) begin
        rsh = {cur.r[k][RW-1:0], 1'b0};
        ge  = rsh >= {1'b0, cur.lq};
        nm_nxt.r[k] = ge ? rsh - {1'b0, cur.lq} : rsh;
        nm_nxt.q[k] = {cur.q[k][QN-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) nm_v_r[j] <= 1'b0;
      else if (ce) nm_v_r[j] <= cur_v;
    end
    always_ff @(posedge clk) begin
      if (ce) nm_r[j] <= nm_nxt;
    end
  end

  // stage c: signed unit direction
  logic                 c_v_r;
  logic signed [DW-1:0] c_d_r [3];
  logic signed [TW-1:0] c_t_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (ce) c_v_r <= nm_v_r[QN-1];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        c_t_r[k] <= nm_r[QN-1].ray.t[k];
        if (nm_r[QN-1].lq == '0) c_d_r[k] <= '0;
        else if (nm_r[QN-1].ray.dn[k]) c_d_r[k] <= -$signed({1'b0, nm_r[QN-1].q[k]});
        else c_d_r[k] <= $signed({1'b0, nm_r[QN-1].q[k]});
      end
    end
  end

  // stage d: cross products
  logic                 d_v_r;
  logic signed [PW-1:0] d_p_r [3];
  logic signed [QW-1:0] d_q_r [3];
  logic signed [TW-1:0] d_t_r [3];
  logic signed [DW-1:0] d_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (ce) d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_p_r[0] <= c_d_r[1] * e2_c[2] - c_d_r[2] * e2_c[1];
      d_p_r[1] <= c_d_r[2] * e2_c[0] - c_d_r[0] * e2_c[2];
      d_p_r[2] <= c_d_r[0] * e2_c[1] - c_d_r[1] * e2_c[0];
      d_q_r[0] <= c_t_r[1] * e1_c[2] - c_t_r[2] * e1_c[1];
      d_q_r[1] <= c_t_r[2] * e1_c[0] - c_t_r[0] * e1_c[2];
      d_q_r[2] <= c_t_r[0] * e1_c[1] - c_t_r[1] * e1_c[0];
      d_t_r    <= c_t_r;
      d_d_r    <= c_d_r;
    end
  end

  // stage e: dot products
  logic                 e_v_r;
  logic signed [SW-1:0] e_det_r, e_un_r, e_vn_r, e_tn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (ce) e_v_r <= d_v_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e_det_r <= e1_c[0] * d_p_r[0] + e1_c[1] * d_p_r[1] + e1_c[2] * d_p_r[2];
      e_un_r  <= d_t_r[0] * d_p_r[0] + d_t_r[1] * d_p_r[1] + d_t_r[2] * d_p_r[2];
      e_vn_r  <= d_d_r[0] * d_q_r[0] + d_d_r[1] * d_q_r[1] + d_d_r[2] * d_q_r[2];
      e_tn_r  <= e2_c[0] * d_q_r[0] + e2_c[1] * d_q_r[1] + e2_c[2] * d_q_r[2];
    end
  end

  // stage f: range decisions and divider setup
  logic                 f_v_r;
  dvst_t                f_r, f_nxt;
  logic signed [SW-1:0] det_m, un2, vn2, tn2;
  logic signed [SW:0]   uv_sum;
  logic [TH_W-1:0]      thr;
  logic [NX_W-1:0]      tn_x, den_x, nd, nu, nv;
  logic                 par;

  always_comb begin
    det_m  = e_det_r[SW-1] ? -e_det_r : e_det_r;
    un2    = e_det_r[SW-1] ? -e_un_r : e_un_r;
    vn2    = e_det_r[SW-1] ? -e_vn_r : e_vn_r;
    tn2    = e_det_r[SW-1] ? -e_tn_r : e_tn_r;
    uv_sum = {un2[SW-1], un2} + {vn2[SW-1], vn2};
    thr    = TH_W'(nz_r) << (2 * FRAC_BITS);
    par    = (e_det_r == '0) || ({{(TH_W-SW){1'b0}}, det_m} < thr);
    tn_x   = NX_W'(unsigned'(tn2));
    den_x  = NX_W'(unsigned'(det_m)) << (DQ - FRAC_BITS);
    nd     = NX_W'(unsigned'(tn2)) << FRAC_BITS;
    nu     = NX_W'(unsigned'(un2)) << BB;
    nv     = NX_W'(unsigned'(vn2)) << BB;
    if (par) f_nxt.cause = rti_pkg::CAUSE_PARALLEL;
    else if (un2 < 0 || un2 > det_m) f_nxt.cause = rti_pkg::CAUSE_U_OUT;
    else if (vn2 < 0 || uv_sum > {det_m[SW-1], det_m}) f_nxt.cause = rti_pkg::CAUSE_V_OUT;
    else if (tn2 <= 0) f_nxt.cause = rti_pkg::CAUSE_BEHIND;
    else f_nxt.cause = rti_pkg::CAUSE_HIT;
    f_nxt.sat       = tn_x >= den_x;
    f_nxt.den       = det_m;
    f_nxt.ln[0].r   = {1'b0, nd[NX_W-1:DQ]};
    f_nxt.ln[0].nlo = nd[DQ-1:0];
    f_nxt.ln[0].q   = '0;
    f_nxt.ln[1].r   = {1'b0, nu[NX_W-1:DQ]};
    f_nxt.ln[1].nlo = nu[DQ-1:0];
    f_nxt.ln[1].q   = '0;
    f_nxt.ln[2].r   = {1'b0, nv[NX_W-1:DQ]};
    f_nxt.ln[2].nlo = nv[DQ-1:0];
    f_nxt.ln[2].q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (ce) f_v_r <= e_v_r;
  end

  always_ff @(posedge clk) begin
    if (ce) f_r <= f_nxt;
  end

  // distance and barycentric divide, one quotient bit per stage
  logic  dv_v_r [DQ];
  dvst_t dv_r   [DQ];

  for (genvar j = 0; j < DQ; j++) begin : g_dv
    localparam int I = DQ - 1 - j;
    dvst_t cur, dv_nxt;
    logic  cur_v;
    if (j == 0) begin : g_first
      assign cur   = f_r;
      assign cur_v = f_v_r;
    end else begin : g_next
      assign cur   = dv_r[j-1];
      assign cur_v = dv_v_r[j-1];
    end
    always_comb begin
      logic [SW:0] rsh;
      logic        ge;
      dv_nxt = cur;
      for (int k = 0; k < 3; k++) begin
        rsh = {cur.ln[k].r[SW-1:0], cur.ln[k].nlo[I]};
        ge  = rsh >= {1'b0, cur.den};
        dv_nxt.ln[k].r = ge ? rsh - {1'b0, cur.den} : rsh;
        dv_nxt.ln[k].q = {cur.ln[k].q[DQ-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (ce) dv_v_r[j] <= cur_v;
    end
    always_ff @(posedge clk) begin
      if (ce) dv_r[j] <= dv_nxt;
    end
  end

  // output register
  dvst_t      fin;
  logic       far_ok;
  logic [2:0] cause_out;
  logic       out_tvalid_r;
  logic [rti_pkg::OUT_DATA_W-1:0] out_tdata_r, data_nxt;
  logic [rti_pkg::OUT_USER_W-1:0] out_tuser_r;

  always_comb begin
    fin    = dv_r[DQ-1];
    far_ok = fin.sat || (fin.ln[0].q > DQ'(nz_r)) ||
             (fin.ln[0].q == DQ'(nz_r) && fin.ln[0].r != '0);
    if (fin.cause != rti_pkg::CAUSE_HIT) cause_out = fin.cause;
    else if (far_ok) cause_out = rti_pkg::CAUSE_HIT;
    else cause_out = rti_pkg::CAUSE_BEHIND;
    data_nxt = '0;
    if (cause_out == rti_pkg::CAUSE_HIT) begin
      data_nxt[DQ-1:0]             = fin.sat ? {DQ{1'b1}} : fin.ln[0].q;
      data_nxt[DQ +: BB+1]         = fin.ln[1].q[BB:0];
      data_nxt[DQ+BB+1 +: BB+1]    = fin.ln[2].q[BB:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (ce) out_tvalid_r <= dv_v_r[DQ-1];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r <= data_nxt;
      out_tuser_r <= {cause_out, cause_out == rti_pkg::CAUSE_HIT};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/core/rti_checker.sv =====
module rti_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rti_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [rti_pkg::OUT_USER_W-1:0]  out_tuser
);

  localparam int DQ = rti_pkg::DIST_BITS;
  localparam int BB = rti_pkg::BARY_BITS;
  localparam logic [BB+1:0] BARY_ONE = (BB+2)'(1) << BB;

  logic [BB+1:0] uv_sum;
  assign uv_sum = (BB+2)'(out_tdata[DQ +: BB+1]) + (BB+2)'(out_tdata[DQ+BB+1 +: BB+1]);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_hit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[0] == (out_tuser[3:1] == rti_pkg::CAUSE_HIT))
    else $error("hit flag disagrees with miss cause");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("miss transaction carries nonzero fields");

  a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> uv_sum <= BARY_ONE)
    else $error("barycentrics exceed one");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
